// ----- rtl/crlf_pkg.sv -----
// Package with shared types and constants for the CR LF record deframer.
`default_nettype none

package crlf_pkg;

    localparam int unsigned COUNT_W = 16;

    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_NOTICE
    } state_t;

    typedef struct packed {
        logic accept_byte;
        logic advance;
        logic show_notice;
    } cmd_t;

    typedef struct packed {
        logic record_end;
        logic len_zero;
        logic len_over;
        logic overflow;
        logic idx_last;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/crlf_ctrl.sv -----
// Controller state machine that sequences byte intake, record emission and drop notices.
`default_nettype none

module crlf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire crlf_pkg::status_t status,
    output crlf_pkg::cmd_t         cmd
);

    crlf_pkg::state_t state_reg;
    crlf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crlf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crlf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (status.record_end)
                    begin
                        priority if (status.len_over)
                        begin
                            state_next = crlf_pkg::ST_NOTICE;
                        end
                        else if (status.len_zero)
                        begin
                            state_next = crlf_pkg::ST_IDLE;
                        end
                        else
                        begin
                            state_next = crlf_pkg::ST_EMIT;
                        end
                    end
                    else if (status.overflow)
                    begin
                        state_next = crlf_pkg::ST_NOTICE;
                    end
                    else
                    begin
                        state_next = crlf_pkg::ST_IDLE;
                    end
                end
            end
            crlf_pkg::ST_EMIT:
            begin
                if (out_ready && status.idx_last)
                begin
                    state_next = crlf_pkg::ST_IDLE;
                end
            end
            crlf_pkg::ST_NOTICE:
            begin
                if (out_ready)
                begin
                    state_next = crlf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crlf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        cmd.accept_byte = 1'b0;
        cmd.advance     = 1'b0;
        cmd.show_notice = 1'b0;
        unique case (state_reg)
            crlf_pkg::ST_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.accept_byte = in_valid;
            end
            crlf_pkg::ST_EMIT:
            begin
                out_valid   = 1'b1;
                cmd.advance = out_ready;
            end
            crlf_pkg::ST_NOTICE:
            begin
                out_valid       = 1'b1;
                cmd.show_notice = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/crlf_dpath.sv -----
// Datapath with the record store, pending count, held CR flag and emission index.
`default_nettype none

module crlf_dpath #(
    parameter int unsigned MAX_RECORD  = 64,
    parameter int unsigned MAX_PENDING = 128
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        data_byte,
    input  wire crlf_pkg::cmd_t    cmd,
    output crlf_pkg::status_t      status,
    output logic [7:0]             record_byte,
    output logic                   last_of_record,
    output logic                   drop_notice
);

    localparam int unsigned IDX_W = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;
    localparam int unsigned LEN_W = $clog2(MAX_RECORD + 1);
    localparam logic [crlf_pkg::COUNT_W-1:0] REC_LIMIT = crlf_pkg::COUNT_W'(MAX_RECORD);
    localparam logic [crlf_pkg::COUNT_W-1:0] PEND_LIMIT = crlf_pkg::COUNT_W'(MAX_PENDING);

    logic [7:0] store_mem [0:MAX_RECORD-1];

    logic [crlf_pkg::COUNT_W-1:0] count_reg;
    logic [crlf_pkg::COUNT_W-1:0] count_next;
    logic                         held_cr_reg;
    logic                         held_cr_next;
    logic [IDX_W-1:0]             idx_reg;
    logic [IDX_W-1:0]             idx_next;
    logic [LEN_W-1:0]             len_reg;
    logic [LEN_W-1:0]             len_next;
    logic [7:0]                   rd_data_reg;
    logic [crlf_pkg::COUNT_W-1:0] len_full;
    logic                         store_write;

    assign len_full = count_reg - crlf_pkg::COUNT_W'(1);

    assign status.record_end = held_cr_reg && (data_byte == crlf_pkg::LF_BYTE);
    assign status.len_zero   = (len_full == '0);
    assign status.len_over   = (len_full > REC_LIMIT);
    assign status.overflow   = (count_reg >= PEND_LIMIT);
    assign status.idx_last   = ({{(LEN_W + 1 - IDX_W){1'b0}}, idx_reg}
                               == ({1'b0, len_reg} - (LEN_W + 1)'(1)));

    assign store_write = cmd.accept_byte && !status.record_end && (count_reg < REC_LIMIT);

    always_comb
    begin
        count_next   = count_reg;
        held_cr_next = held_cr_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        if (cmd.accept_byte)
        begin
            if (status.record_end)
            begin
                count_next   = '0;
                held_cr_next = 1'b0;
                idx_next     = '0;
                len_next     = len_full[LEN_W-1:0];
            end
            else if (status.overflow)
            begin
                count_next   = '0;
                held_cr_next = 1'b0;
            end
            else
            begin
                count_next   = count_reg + crlf_pkg::COUNT_W'(1);
                held_cr_next = (data_byte == crlf_pkg::CR_BYTE);
            end
        end
        else if (cmd.advance)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            held_cr_reg <= 1'b0;
            idx_reg     <= '0;
            len_reg     <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            held_cr_reg <= held_cr_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_write)
        begin
            store_mem[count_reg[IDX_W-1:0]] <= data_byte;
        end
        rd_data_reg <= store_mem[idx_next];
    end

    assign record_byte    = cmd.show_notice ? 8'h00 : rd_data_reg;
    assign last_of_record = cmd.show_notice || status.idx_last;
    assign drop_notice    = cmd.show_notice;

endmodule

`default_nettype wire

// ----- rtl/crlf_record_deframer.sv -----
// Top level of the CR LF record deframer: controller, datapath and checks.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    data_byte
// output    out        out_valid / out_ready  record_byte, last_of_record, drop_notice
//
// Input is taken only while idle; the block holds in_ready low while results go out.
// Records stream one byte per cycle while out_ready is high, via the registered store read port.
// A drop notice is a single output transaction; an empty record produces nothing.
// Reset clears the pending count and held CR at once; the record store needs no clearing.
// A stalled output holds its transaction and the input stays blocked until it is taken.
`default_nettype none

module crlf_record_deframer #(
    parameter int unsigned MAX_RECORD  = 64,
    parameter int unsigned MAX_PENDING = 128
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      record_byte,
    output logic            last_of_record,
    output logic            drop_notice
);

    crlf_pkg::cmd_t    cmd;
    crlf_pkg::status_t status;

    crlf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    crlf_dpath #(
        .MAX_RECORD  (MAX_RECORD),
        .MAX_PENDING (MAX_PENDING)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .cmd            (cmd),
        .status         (status),
        .record_byte    (record_byte),
        .last_of_record (last_of_record),
        .drop_notice    (drop_notice)
    );

    // The block never takes input while a result is on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output offered together");

    // After the final transaction of a record or notice, input is taken again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_of_record) |=> in_ready)
        else $error("block did not return to intake after a record");

    // Only an LF can start the emission of record bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (data_byte != crlf_pkg::LF_BYTE))
        |=> !(out_valid && !drop_notice))
        else $error("record emission started without LF");

endmodule

`default_nettype wire
